/* rtl/rmfp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_pkg
// Shared types and constants for the rotated monochrome framebuffer block.
// ============================================================================
package rmfp_pkg;

    localparam int FB_BYTES = 1024;
    localparam int FB_AW    = $clog2(FB_BYTES);
    localparam int OFF_W    = 21;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_X    = 2'd1;
    localparam logic [1:0] ST_Y    = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;
    localparam logic [1:0] ROT_FLIP = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROT    = 3'd2;
    localparam logic [2:0] REG_LSB    = 3'd3;
    localparam logic [2:0] REG_BUF    = 3'd4;

    typedef struct packed {
        logic [10:0] width_px;
        logic [10:0] height_px;
        logic [1:0]  rotation_mode;
        logic        lsb_first;
        logic [10:0] buffer_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [FB_AW-1:0] addr;
        logic [7:0]       mask;
    } entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACCESS
    } back_state_t;

endpackage

/* rtl/rmfp_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rmfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rmfp_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_front
// Accepts requests, checks bounds, rotates to buffer coordinates and forms
// the byte address, bit mask and status of each request.
// ============================================================================
module rmfp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmfp_pkg::cfg_t        cfg,
    input  logic                  clearing,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            kind,
    input  logic [9:0]            pos_x,
    input  logic [9:0]            pos_y,
    output logic                  q_push,
    output rmfp_pkg::entry_t      q_data,
    input  logic                  q_full
);

    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_kind_reg;
    logic [1:0]  s1_status_reg;
    logic [10:0] s1_bx_reg;
    logic [10:0] s1_by_reg;
    logic [8:0]  s1_stride_reg;
    logic [7:0]  s1_mask_reg;

    logic        accept;
    logic [10:0] x_ext, y_ext, w_m1, h_m1;
    logic [10:0] bw, bx, by;
    logic [11:0] bw_round;
    logic [1:0]  st1;
    logic [7:0]  mask;

    logic [19:0]            prod;
    logic [rmfp_pkg::OFF_W-1:0] offset;
    logic                   overflow;

    assign req_stall = clearing || (s1_valid_reg && q_full);
    assign accept    = req_valid && !req_stall;
    assign q_push    = s1_valid_reg && !q_full;

    // Stage one: bounds checks and rotation.
    always_comb
    begin
        x_ext = {1'b0, pos_x};
        y_ext = {1'b0, pos_y};
        w_m1  = cfg.width_px - x_ext - 11'd1;
        h_m1  = cfg.height_px - y_ext - 11'd1;

        if (x_ext >= cfg.width_px)
        begin
            st1 = rmfp_pkg::ST_X;
        end
        else if (y_ext >= cfg.height_px)
        begin
            st1 = rmfp_pkg::ST_Y;
        end
        else
        begin
            st1 = rmfp_pkg::ST_OK;
        end

        case (cfg.rotation_mode)
            rmfp_pkg::ROT_NONE:
            begin
                bw = cfg.width_px;
                bx = x_ext;
                by = y_ext;
            end
            rmfp_pkg::ROT_CW:
            begin
                bw = cfg.height_px;
                bx = h_m1;
                by = x_ext;
            end
            rmfp_pkg::ROT_CCW:
            begin
                bw = cfg.height_px;
                bx = y_ext;
                by = w_m1;
            end
            default:
            begin
                bw = cfg.width_px;
                bx = w_m1;
                by = h_m1;
            end
        endcase

        bw_round = {1'b0, bw} + 12'd7;
        mask     = cfg.lsb_first ? (8'h01 << bx[2:0]) : (8'h80 >> bx[2:0]);
        s1_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind;
            s1_status_reg <= st1;
            s1_bx_reg     <= bx;
            s1_by_reg     <= by;
            s1_stride_reg <= bw_round[11:3];
            s1_mask_reg   <= mask;
        end
    end

    // Stage two: byte offset and the overflow check.
    always_comb
    begin
        prod     = s1_by_reg * s1_stride_reg;
        offset   = rmfp_pkg::OFF_W'(prod) + rmfp_pkg::OFF_W'(s1_bx_reg[10:3]);
        overflow = (offset >= rmfp_pkg::OFF_W'(cfg.buffer_bytes))
                || (offset >= rmfp_pkg::OFF_W'(rmfp_pkg::FB_BYTES));

        q_data.kind   = s1_kind_reg;
        q_data.status = ((s1_status_reg == rmfp_pkg::ST_OK) && overflow)
                      ? rmfp_pkg::ST_OVF : s1_status_reg;
        q_data.addr   = offset[rmfp_pkg::FB_AW-1:0];
        q_data.mask   = s1_mask_reg;
    end

endmodule

/* rtl/rmfp_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_queue
// Short FIFO of classified requests between the front and the back.
// ============================================================================
module rmfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rmfp_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output rmfp_pkg::entry_t head
);

    rmfp_pkg::entry_t              slot_reg [rmfp_pkg::Q_DEPTH];
    logic [rmfp_pkg::Q_PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rmfp_pkg::Q_PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rmfp_pkg::Q_CW-1:0]     count_reg, count_next;

    localparam logic [rmfp_pkg::Q_PW-1:0] LAST = rmfp_pkg::Q_PW'(rmfp_pkg::Q_DEPTH - 1);

    assign full       = (count_reg == rmfp_pkg::Q_CW'(rmfp_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + rmfp_pkg::Q_PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + rmfp_pkg::Q_PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + rmfp_pkg::Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - rmfp_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/rmfp_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_back
// Clears the frame store after reset, then carries out queued requests as
// read-modify-write accesses and presents each response.
// ============================================================================
module rmfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  rmfp_pkg::entry_t head,
    output logic             pop,
    output logic             clearing,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [1:0]       status,
    output logic             pixel_on
);

    rmfp_pkg::back_state_t       state_reg, state_next;
    logic [rmfp_pkg::FB_AW-1:0]  clr_addr_reg, clr_addr_next;
    rmfp_pkg::entry_t            cur_reg, cur_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic                        pixel_reg, pixel_next;

    logic                        we;
    logic [rmfp_pkg::FB_AW-1:0]  waddr;
    logic [7:0]                  wdata;
    logic [rmfp_pkg::FB_AW-1:0]  raddr;
    logic [7:0]                  rdata;
    logic                        out_free;

    rmfp_ram #(
        .WIDTH (8),
        .DEPTH (rmfp_pkg::FB_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign clearing  = (state_reg == rmfp_pkg::BK_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign pixel_on  = pixel_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_next       = cur_reg;
        rsp_valid_next = (rsp_valid_reg && !rsp_stall) ? 1'b0 : rsp_valid_reg;
        status_next    = status_reg;
        pixel_next     = pixel_reg;
        out_free       = !rsp_valid_reg || !rsp_stall;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = cur_reg.addr;
        wdata          = rdata;
        raddr          = head.addr;

        unique case (state_reg)
            rmfp_pkg::BK_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_addr_reg;
                wdata = 8'h00;
                if (clr_addr_reg == rmfp_pkg::FB_AW'(rmfp_pkg::FB_BYTES - 1))
                begin
                    state_next = rmfp_pkg::BK_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + rmfp_pkg::FB_AW'(1);
                end
            end
            rmfp_pkg::BK_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    if (head.status != rmfp_pkg::ST_OK)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = head.status;
                        pixel_next     = 1'b0;
                    end
                    else
                    begin
                        cur_next   = head;
                        state_next = rmfp_pkg::BK_ACCESS;
                    end
                end
            end
            rmfp_pkg::BK_ACCESS:
            begin
                // The output register was freed when this request was popped.
                if (cur_reg.kind == rmfp_pkg::KIND_SET)
                begin
                    we    = 1'b1;
                    wdata = rdata | cur_reg.mask;
                end
                else if (cur_reg.kind == rmfp_pkg::KIND_CLEAR)
                begin
                    we    = 1'b1;
                    wdata = rdata & ~cur_reg.mask;
                end
                rsp_valid_next = 1'b1;
                status_next    = rmfp_pkg::ST_OK;
                pixel_next     = (cur_reg.kind == rmfp_pkg::KIND_READ)
                              && ((rdata & cur_reg.mask) != 8'h00);
                state_next     = rmfp_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = rmfp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmfp_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        status_reg <= status_next;
        pixel_reg  <= pixel_next;
    end

endmodule

/* rtl/rotated_mono_framebuffer_pixel.sv */
`timescale 1ns / 1ps
// ============================================================================
// rotated_mono_framebuffer_pixel
// One-bit-per-pixel framebuffer with rotated set, clear and read access to
// single pixels, and an APB-style register port for the geometry.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ----------------------------------------
//  request   req_valid / req_stall  kind, pos_x, pos_y
//  response  rsp_valid / rsp_stall  status, pixel_on
//  config    psel/penable/pready    paddr, pwdata, prdata
//
// In the front a request is registered after the bounds checks and rotation,
// and the offset multiply then feeds a two-entry queue. A request that fails
// a check is answered by the back without a store access; one that reaches
// the store takes a registered read and then, for set and clear, the write
// back. After reset the back sweeps the store to zero, one byte a cycle;
// req_stall stays high during that pass. A stalled response holds the
// back; the queue and front register then hold up to three more requests.
// ============================================================================
module rotated_mono_framebuffer_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  kind,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic        pixel_on
);

    rmfp_pkg::cfg_t   cfg_reg, cfg_next;
    logic [2:0]       reg_index;
    logic             cfg_write;

    logic             clearing;
    logic             q_push, q_full, q_pop, q_head_valid;
    rmfp_pkg::entry_t q_in, q_head;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = 32'h0;
        unique case (reg_index)
            rmfp_pkg::REG_WIDTH:
            begin
                prdata = {21'h0, cfg_reg.width_px};
                if (cfg_write) cfg_next.width_px = pwdata[10:0];
            end
            rmfp_pkg::REG_HEIGHT:
            begin
                prdata = {21'h0, cfg_reg.height_px};
                if (cfg_write) cfg_next.height_px = pwdata[10:0];
            end
            rmfp_pkg::REG_ROT:
            begin
                prdata = {30'h0, cfg_reg.rotation_mode};
                if (cfg_write) cfg_next.rotation_mode = pwdata[1:0];
            end
            rmfp_pkg::REG_LSB:
            begin
                prdata = {31'h0, cfg_reg.lsb_first};
                if (cfg_write) cfg_next.lsb_first = pwdata[0];
            end
            rmfp_pkg::REG_BUF:
            begin
                prdata = {21'h0, cfg_reg.buffer_bytes};
                if (cfg_write) cfg_next.buffer_bytes = pwdata[10:0];
            end
            default:
            begin
                prdata = 32'h0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_px      <= 11'd128;
            cfg_reg.height_px     <= 11'd64;
            cfg_reg.rotation_mode <= rmfp_pkg::ROT_NONE;
            cfg_reg.lsb_first     <= 1'b0;
            cfg_reg.buffer_bytes  <= 11'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rmfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    rmfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    rmfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .clearing   (clearing),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .pixel_on   (pixel_on)
    );

endmodule

/* rtl/rmfp_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmfp_checker
// Port-level checks for the rotated framebuffer block, bound to the top.
// ============================================================================
module rmfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [1:0] status,
    input logic       pixel_on
);

    // A held response keeps its contents until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(pixel_on))
        else $error("stalled response changed");

    // A lit pixel is only ever reported by a successful request.
    a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pixel_on |-> status == rmfp_pkg::ST_OK)
        else $error("pixel_on set on a failed request");

    // The store clearing pass blocks requests right after reset.
    a_clear_stall: assert property (@(posedge clk)
        $rose(rst_n) |-> req_stall)
        else $error("request accepted during store clearing");

    // No response can appear in the cycle after reset is released.
    a_no_early_rsp: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response before any request");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind rotated_mono_framebuffer_pixel rmfp_checker u_rmfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .pixel_on  (pixel_on)
);
